// ===== rtl/fltw_pkg.sv =====
// Shared types, constants and helpers for the four-level page table walker.
// Used by fltw_walker and four_level_page_table_walk; no dependencies.
package fltw_pkg;

  localparam int unsigned MEM_WORDS = 4096;
  localparam int unsigned AW        = $clog2(MEM_WORDS);
  localparam int unsigned WORD_W    = 64;
  localparam int unsigned VA_W      = 48;
  localparam int unsigned PG_SHIFT  = 12;
  localparam int unsigned PN_W      = WORD_W - PG_SHIFT;
  localparam int unsigned IDX_W     = 9;
  localparam int unsigned ST_W      = 3;
  localparam int unsigned LVL_W     = 2;

  // func field
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_XLATE = 1'b1;

  // status codes
  localparam logic [ST_W-1:0] ST_OK   = 3'd0;
  localparam logic [ST_W-1:0] ST_TOP  = 3'd1;
  localparam logic [ST_W-1:0] ST_L2   = 3'd2;
  localparam logic [ST_W-1:0] ST_L3   = 3'd3;
  localparam logic [ST_W-1:0] ST_LEAF = 3'd4;

  // walk levels, top table first
  localparam logic [LVL_W-1:0] LVL_LEAF = 2'd0;
  localparam logic [LVL_W-1:0] LVL_3    = 2'd1;
  localparam logic [LVL_W-1:0] LVL_2    = 2'd2;
  localparam logic [LVL_W-1:0] LVL_TOP  = 2'd3;

  typedef struct packed {
    logic              we;
    logic [AW-1:0]     waddr;
    logic [WORD_W-1:0] wdata;
    logic              re;
    logic [AW-1:0]     raddr;
  } mem_req_t;

  function automatic logic [IDX_W-1:0] level_index(logic [VA_W-1:0] va,
                                                   logic [LVL_W-1:0] lvl);
    logic [IDX_W-1:0] idx;
    unique case (lvl)
      LVL_LEAF: idx = va[20:12];
      LVL_3:    idx = va[29:21];
      LVL_2:    idx = va[38:30];
      LVL_TOP:  idx = va[47:39];
      default:  idx = '0;
    endcase
    return idx;
  endfunction

  function automatic logic [ST_W-1:0] level_status(logic [LVL_W-1:0] lvl);
    logic [ST_W-1:0] st;
    unique case (lvl)
      LVL_TOP:  st = ST_TOP;
      LVL_2:    st = ST_L2;
      LVL_3:    st = ST_L3;
      LVL_LEAF: st = ST_LEAF;
      default:  st = ST_OK;
    endcase
    return st;
  endfunction

  // Table base is page aligned and idx*8 stays below one page, so the
  // word address is just {page number, index} wrapped to the store depth.
  function automatic logic [AW-1:0] word_addr(logic [PN_W-1:0] pn,
                                              logic [IDX_W-1:0] idx);
    logic [PN_W+IDX_W-1:0] full;
    full = {pn, idx};
    return full[AW-1:0];
  endfunction

endpackage

// ===== rtl/fltw_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module fltw_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/fltw_walker.sv =====
// Walk sequencer: store clearing pass, word writes, four-level table walk
// and the result register. Depends on fltw_pkg; drives the table store.
module fltw_walker
  import fltw_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [PN_W-1:0]   root_pn_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              func_i,
  input  logic [VA_W-1:0]   addr_i,
  input  logic [WORD_W-1:0] data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [WORD_W-1:0] phys_addr_o,
  output logic [ST_W-1:0]   status_o,
  output mem_req_t          mem_req_o,
  input  logic [WORD_W-1:0] mem_rdata_i
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_WALK  = 2'd2;

  localparam logic [AW-1:0] CLR_LAST = AW'(MEM_WORDS - 1);

  logic [1:0]        state_q, state_d;
  logic [AW-1:0]     clr_cnt_q, clr_cnt_d;
  logic [LVL_W-1:0]  lvl_q, lvl_d;
  logic [VA_W-1:0]   va_q, va_d;
  logic              out_valid_q, out_valid_d;
  logic [WORD_W-1:0] phys_q, phys_d;
  logic [ST_W-1:0]   status_q, status_d;
  logic              accept;
  logic [PN_W-1:0]   ent_pn;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign ent_pn     = mem_rdata_i[WORD_W-1:PG_SHIFT];

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    lvl_d       = lvl_q;
    va_d        = va_q;
    out_valid_d = out_valid_q;
    phys_d      = phys_q;
    status_d    = status_q;
    mem_req_o   = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = clr_cnt_q;
        clr_cnt_d       = clr_cnt_q + 1'b1;
        if (clr_cnt_q == CLR_LAST) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (func_i == FUNC_WRITE) begin
            mem_req_o.we    = 1'b1;
            mem_req_o.waddr = addr_i[AW+2:3];
            mem_req_o.wdata = data_i;
            out_valid_d     = 1'b1;
            phys_d          = '0;
            status_d        = ST_OK;
          end else begin
            mem_req_o.re    = 1'b1;
            mem_req_o.raddr = word_addr(root_pn_i, level_index(addr_i, LVL_TOP));
            va_d            = addr_i;
            lvl_d           = LVL_TOP;
            state_d         = S_WALK;
          end
        end
      end
      S_WALK: begin
        // entry for lvl_q is on the read port this cycle
        if (ent_pn == '0) begin
          out_valid_d = 1'b1;
          phys_d      = '0;
          status_d    = level_status(lvl_q);
          state_d     = S_IDLE;
        end else if (lvl_q == LVL_LEAF) begin
          out_valid_d = 1'b1;
          phys_d      = {ent_pn, va_q[PG_SHIFT-1:0]};
          status_d    = ST_OK;
          state_d     = S_IDLE;
        end else begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = word_addr(ent_pn, level_index(va_q, lvl_q - 1'b1));
          lvl_d           = lvl_q - 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      lvl_q       <= LVL_TOP;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      lvl_q       <= lvl_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    va_q     <= va_d;
    phys_q   <= phys_d;
    status_q <= status_d;
  end

  assign out_valid_o = out_valid_q;
  assign phys_addr_o = phys_q;
  assign status_o    = status_q;

`ifndef SYNTHESIS
  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == S_IDLE)
    else $error("input ready outside idle");

  a_walk_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WALK |-> !out_valid_q)
    else $error("result register busy during walk");

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_req_o.we && mem_req_o.re))
    else $error("store read and write in one cycle");

  a_xlate_starts_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && func_i == FUNC_XLATE) |=> state_q == S_WALK && lvl_q == LVL_TOP)
    else $error("translate transaction did not start a walk");

  a_fail_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> phys_addr_o == '0)
    else $error("failed walk with nonzero address");
`endif

endmodule

// ===== rtl/four_level_page_table_walk.sv =====
// Four-level page table walker over a 4096 x 64-bit table store.
// After reset the store is swept to zero, one word per cycle; input
// transactions are held off until it ends, while the root base register
// can be written at any time. A write transaction writes the store in its
// accept cycle. In a translate transaction the accept cycle issues the
// top-level read, then each level waits on the store's single registered
// read port before the next dependent read, and the result lands in an
// output register. One item is in flight at a time; a waiting result
// holds off the input, and the next one is accepted no earlier than the
// cycle in which the previous result is taken.
// Depends on fltw_pkg, fltw_ram and fltw_walker.
module four_level_page_table_walk
  import fltw_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              func_i,
  input  logic [VA_W-1:0]   addr_i,
  input  logic [WORD_W-1:0] data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [WORD_W-1:0] phys_addr_o,
  output logic [ST_W-1:0]   status_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [WORD_W-1:0] cfg_data_i
);

  logic [PN_W-1:0]   root_pn_q;
  mem_req_t          mem_req;
  logic [WORD_W-1:0] mem_rdata;

  assign cfg_ready_o = 1'b1;

  // low 12 bits of the root base are ignored, so only the page number is kept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_pn_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      root_pn_q <= cfg_data_i[WORD_W-1:PG_SHIFT];
    end
  end

  fltw_walker u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .root_pn_i   (root_pn_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .addr_i      (addr_i),
    .data_i      (data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .phys_addr_o (phys_addr_o),
    .status_o    (status_o),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  fltw_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MEM_WORDS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for four_level_page_table_walk: builds page tables through
// the write path and checks each result against a walk done here or a directed
// expectation. Needs fltw_pkg and the walker RTL; no files or arguments.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fltw_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0] phys_addr;
    logic [ST_W-1:0]   status;
  } xlate_result_t;

  typedef struct packed {
    logic              func;
    logic [VA_W-1:0]   addr;
    logic [WORD_W-1:0] data;
    logic              typed;
    xlate_result_t     res;
  } stim_row_t;

  localparam int unsigned RAND_ITEMS   = 1650;
  localparam int unsigned N_PHASES     = 6;
  localparam int unsigned CYCLE_LIMIT  = 400_000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned MAX_GAP      = 17;
  localparam logic [WORD_W-1:0] ROOT_MAX = 64'hFFFF_FFFF_FFFF_F000;
  localparam logic [WORD_W-1:0] PG_MASK  = {{PN_W{1'b1}}, {PG_SHIFT{1'b0}}};
  localparam xlate_result_t     WR_DONE  = '{64'h0, ST_OK};

  // fault code for a zero entry at walk level 4 (top) down to 1 (leaf)
  localparam logic [ST_W-1:0] FAULT_CODE [1:4] = '{ST_LEAF, ST_L3, ST_L2, ST_TOP};

  localparam int unsigned DIR_ROWS = 18;
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    '{FUNC_XLATE, 48'h0000_0000_0000, 64'h0, 1'b1, '{64'h0, ST_TOP}},
    '{FUNC_XLATE, 48'hFFFF_FFFF_FFFF, 64'h0, 1'b1, '{64'h0, ST_TOP}},
    // top entry with only flag bits set still counts as empty
    '{FUNC_WRITE, 48'h0000_0000_0000, 64'h0000_0000_0000_0FFF, 1'b1, WR_DONE},
    '{FUNC_XLATE, 48'h0000_0000_0000, 64'h0, 1'b1, '{64'h0, ST_TOP}},
    '{FUNC_WRITE, 48'h0000_0000_0000, 64'h0000_0000_0000_1000, 1'b1, WR_DONE},
    '{FUNC_XLATE, 48'h0000_0000_0000, 64'h0, 1'b1, '{64'h0, ST_L2}},
    '{FUNC_WRITE, 48'h0000_0000_1000, 64'h0000_0000_0000_2000, 1'b1, WR_DONE},
    '{FUNC_XLATE, 48'h0000_0000_0000, 64'h0, 1'b1, '{64'h0, ST_L3}},
    '{FUNC_WRITE, 48'h0000_0000_2000, 64'h0000_0000_0000_3000, 1'b1, WR_DONE},
    '{FUNC_XLATE, 48'h0000_0000_0000, 64'h0, 1'b1, '{64'h0, ST_LEAF}},
    '{FUNC_WRITE, 48'h0000_0000_3000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, WR_DONE},
    '{FUNC_XLATE, 48'h0000_0000_0ABC, 64'h0, 1'b1, '{64'hFFFF_FFFF_FFFF_FABC, ST_OK}},
    '{FUNC_XLATE, 48'h0000_0000_0FFF, 64'h0, 1'b1, '{64'hFFFF_FFFF_FFFF_FFFF, ST_OK}},
    // all-ones path; store address wraps, low byte-address bits ignored
    '{FUNC_WRITE, 48'hFFFF_FFFF_FFFF, 64'h0000_0000_0000_5FFF, 1'b1, WR_DONE},
    '{FUNC_WRITE, 48'h0000_0000_0FF8, 64'h8000_0000_0000_7000, 1'b1, WR_DONE},
    '{FUNC_WRITE, 48'h0000_0000_5FF8, 64'h7FFF_FFFF_FFFF_E123, 1'b1, WR_DONE},
    '{FUNC_WRITE, 48'h0000_0000_6FF8, 64'h0123_4567_89AB_C000, 1'b1, WR_DONE},
    '{FUNC_XLATE, 48'hFFFF_FFFF_FFFF, 64'h0, 1'b0, '{64'h0, ST_OK}}
  };

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              func_i      = FUNC_WRITE;
  logic [VA_W-1:0]   addr_i      = '0;
  logic [WORD_W-1:0] data_i      = '0;
  logic              out_ready_i = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic [WORD_W-1:0] cfg_data_i  = '0;
  logic              in_ready_o;
  logic              out_valid_o;
  logic [WORD_W-1:0] phys_addr_o;
  logic [ST_W-1:0]   status_o;
  logic              cfg_ready_o;

  four_level_page_table_walk i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .addr_i      (addr_i),
    .data_i      (data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .phys_addr_o (phys_addr_o),
    .status_o    (status_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow copy of the table store and root register
  logic [WORD_W-1:0] shadow_store [MEM_WORDS];
  logic [WORD_W-1:0] shadow_root;
  xlate_result_t     pending_results [$];

  int unsigned n_items   = 0;
  int unsigned n_writes  = 0;
  int unsigned n_roots   = 0;
  int unsigned fails     = 0;
  int unsigned cycle_cnt = 0;
  int unsigned by_status [8];
  bit          in_calm   = 1'b0;
  bit          out_calm  = 1'b0;

  function automatic logic [WORD_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  function automatic logic [AW-1:0] table_word(logic [WORD_W-1:0] base,
                                               logic [IDX_W-1:0] idx);
    logic [WORD_W-1:0] byte_addr;
    byte_addr = base + {idx, 3'b000};
    return byte_addr[AW+2:3];
  endfunction

  function automatic xlate_result_t walk_tables(logic [VA_W-1:0] va);
    logic [WORD_W-1:0] base;
    logic [WORD_W-1:0] ent;
    xlate_result_t     r;
    base = shadow_root & PG_MASK;
    r = '{64'h0, ST_OK};
    for (int lvl = 4; lvl >= 1; lvl--) begin
      ent = shadow_store[table_word(base, va[PG_SHIFT + IDX_W*(lvl-1) +: IDX_W])];
      base = ent & PG_MASK;
      if (base == '0) begin
        r.status = FAULT_CODE[lvl];
        return r;
      end
    end
    r.phys_addr = base | va[PG_SHIFT-1:0];
    return r;
  endfunction

  task automatic issue_item(input logic func, input logic [VA_W-1:0] addr,
                            input logic [WORD_W-1:0] data, input logic typed,
                            input xlate_result_t typed_res);
    int gap;
    xlate_result_t r;
    if (n_items % 40 == 0) in_calm = ($urandom_range(0, 3) == 0);
    gap = draw_gap(in_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= func;
    addr_i     <= addr;
    data_i     <= data;
    do @(posedge clk_i); while (!in_ready_o);
    if (func == FUNC_WRITE) begin
      shadow_store[addr[AW+2:3]] = data;
      r = WR_DONE;
      n_writes++;
    end else begin
      r = walk_tables(addr);
    end
    if (typed) r = typed_res;
    pending_results.push_back(r);
    n_items++;
  endtask

  // waits until no transaction is outstanding, then writes the root register
  task automatic write_root(input logic [WORD_W-1:0] value);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    shadow_root = value;
    n_roots++;
  endtask

  // write a path of table entries for a random address, sometimes reusing
  // existing entries or planting an empty one, then translate through it and up to two nearby addresses
  task automatic build_walk();
    logic [VA_W-1:0]   va;
    logic [WORD_W-1:0] base;
    logic [WORD_W-1:0] ent;
    logic [WORD_W-1:0] rnd;
    logic [AW-1:0]     w;
    int                brk;
    int                extra;
    rnd  = rand64();
    va   = rnd[VA_W-1:0];
    base = shadow_root & PG_MASK;
    brk  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : 0;
    for (int lvl = 4; lvl >= 1; lvl--) begin
      w = table_word(base, va[PG_SHIFT + IDX_W*(lvl-1) +: IDX_W]);
      rnd = rand64();
      if (lvl == brk) begin
        ent = {{PN_W{1'b0}}, rnd[PG_SHIFT-1:0]};
      end else if ($urandom_range(0, 4) == 0 && shadow_store[w][WORD_W-1:PG_SHIFT] != '0) begin
        ent = shadow_store[w];
      end else begin
        ent = rand64();
        if (ent[WORD_W-1:PG_SHIFT] == '0) ent[PG_SHIFT] = 1'b1;
      end
      if (ent != shadow_store[w] || lvl == brk)
        issue_item(FUNC_WRITE, {rnd[VA_W-1:AW+3], w, rnd[2:0]}, ent, 1'b0, '0);
      if (lvl == brk) break;
      base = ent & PG_MASK;
    end
    issue_item(FUNC_XLATE, va, rand64(), 1'b0, '0);
    extra = $urandom_range(0, 2);
    repeat (extra) begin
      rnd = rand64();
      if ($urandom_range(0, 1) == 0)
        issue_item(FUNC_XLATE, {va[VA_W-1:PG_SHIFT], rnd[PG_SHIFT-1:0]}, rnd, 1'b0, '0);
      else
        issue_item(FUNC_XLATE, {va[VA_W-1:21], rnd[20:0]}, rnd, 1'b0, '0);
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    xlate_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: phys_addr %h status %0d", phys_addr_o, status_o);
        fails++;
      end else begin
        want = pending_results.pop_front();
        if (phys_addr_o !== want.phys_addr) begin
          $error("phys_addr: expected %h, got %h", want.phys_addr, phys_addr_o);
          fails++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          fails++;
        end
        by_status[want.status]++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("four_level_page_table_walk: mismatch");
      $finish;
    end
  end

  initial begin : result_sink
    int gap;
    int taken;
    taken = 0;
    @(posedge rst_ni);
    forever begin
      if (taken % 40 == 0) out_calm = ($urandom_range(0, 3) == 0);
      gap = draw_gap(out_calm);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
    end
  end

  initial begin : stimulus
    logic [WORD_W-1:0] roots [N_PHASES];
    logic [WORD_W-1:0] rnd;
    int unsigned       rand_start;
    int unsigned       stop_at;
    foreach (shadow_store[i]) shadow_store[i] = '0;
    shadow_root = '0;
    rnd = rand64();
    if (rnd > ROOT_MAX) rnd = ROOT_MAX;
    roots = '{ROOT_MAX, 64'h0000_0000_0000_0FFF, 64'h5555_5555_5555_5000,
              64'hAAAA_AAAA_AAAA_AFFF, 64'h0000_0000_0000_1000, rnd};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_root('0);
    for (int i = 0; i < DIR_ROWS; i++)
      issue_item(DIRECTED[i].func, DIRECTED[i].addr, DIRECTED[i].data,
                 DIRECTED[i].typed, DIRECTED[i].res);

    rand_start = n_items;
    for (int p = 0; p < N_PHASES; p++) begin
      write_root(roots[p]);
      stop_at = rand_start + (p + 1) * RAND_ITEMS / N_PHASES;
      while (n_items < stop_at) begin
        if ($urandom_range(0, 4) == 0) begin
          rnd = rand64();
          issue_item($urandom_range(0, 1) ? FUNC_XLATE : FUNC_WRITE, rnd[VA_W-1:0],
                     rand64(), 1'b0, '0);
        end else begin
          build_walk();
        end
      end
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d transactions (%0d table writes) over %0d root base settings",
             n_items, n_writes, n_roots);
    $display("translations: %0d mapped, empty entry at top/L2/L3/leaf: %0d/%0d/%0d/%0d",
             by_status[ST_OK] - n_writes, by_status[ST_TOP], by_status[ST_L2],
             by_status[ST_L3], by_status[ST_LEAF]);
    if (fails == 0) begin
      $display("four_level_page_table_walk: match");
    end else begin
      $display("four_level_page_table_walk: mismatch");
    end
    $finish;
  end

endmodule
